@@ src/assert_macros.svh @@
// Assertion macros used by the parser RTL.
// Both macros expect signals named clk and rst in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mclp_pkg.sv @@
// Shared types, codes and name tables of the command line parser.
// No dependencies; used by every module of the parser.
`timescale 1ns / 1ps

package mclp_pkg;

  localparam int TOKEN_MAX_DEF = 24;
  localparam int LINE_MAX_DEF  = 128;
  localparam int ADDR_BITS_DEF = 32;

  // Bytes kept of the command word and of the argument word.
  localparam int CMD_KEEP = 5;
  localparam int ARG_KEEP = 6;

  localparam int POS_W      = 8;
  localparam int REG_W      = 5;
  localparam int ADDR_OUT_W = 32;

  typedef enum logic [3:0] {
    CMD_EMPTY = 4'd0,
    CMD_ERROR = 4'd1,
    CMD_EXIT  = 4'd2,
    CMD_PEEK  = 4'd3,
    CMD_POKE  = 4'd4,
    CMD_ECHO  = 4'd5,
    CMD_REGS  = 4'd6,
    CMD_BIOS  = 4'd7,
    CMD_HELP  = 4'd8,
    CMD_INT   = 4'd9,
    CMD_CPUID = 4'd10
  } command_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_EXTRA   = 2'd1,
    ERR_USAGE   = 2'd2,
    ERR_INVALID = 2'd3
  } error_t;

  typedef struct packed {
    command_t         cmd;
    logic             reg_hit;
    logic [REG_W-1:0] reg_idx;
  } match_t;

  typedef struct packed {
    command_t              command;
    error_t                error_code;
    logic [REG_W-1:0]      reg_index;
    logic [ADDR_OUT_W-1:0] address;
    logic                  addr_set;
    logic                  reg_set;
    logic [POS_W-1:0]      echo_start;
  } result_t;

  // Words are shifted in, so the first byte sits highest and a short word is
  // right-justified, the same way a string literal is.
  function automatic command_t cmd_lookup(input logic [8*CMD_KEEP-1:0] word);
    command_t code;
    case (word)
      40'("exit"):  code = CMD_EXIT;
      40'("peek"):  code = CMD_PEEK;
      40'("poke"):  code = CMD_POKE;
      40'("echo"):  code = CMD_ECHO;
      40'("regs"):  code = CMD_REGS;
      40'("bios"):  code = CMD_BIOS;
      40'("help"):  code = CMD_HELP;
      40'("int"):   code = CMD_INT;
      40'("cpuid"): code = CMD_CPUID;
      default:      code = CMD_ERROR;
    endcase
    return code;
  endfunction

  // The argument is stored upper case, so this table is upper case only.
  function automatic match_t reg_lookup(input logic [8*ARG_KEEP-1:0] word);
    match_t m;
    m.cmd     = CMD_EMPTY;
    m.reg_hit = 1'b1;
    case (word)
      48'("AL"):     m.reg_idx = 5'd0;
      48'("AH"):     m.reg_idx = 5'd1;
      48'("AX"):     m.reg_idx = 5'd2;
      48'("BL"):     m.reg_idx = 5'd3;
      48'("BH"):     m.reg_idx = 5'd4;
      48'("BP"):     m.reg_idx = 5'd5;
      48'("BX"):     m.reg_idx = 5'd6;
      48'("CL"):     m.reg_idx = 5'd7;
      48'("CH"):     m.reg_idx = 5'd8;
      48'("CS"):     m.reg_idx = 5'd9;
      48'("CX"):     m.reg_idx = 5'd10;
      48'("DL"):     m.reg_idx = 5'd11;
      48'("DH"):     m.reg_idx = 5'd12;
      48'("DI"):     m.reg_idx = 5'd13;
      48'("DS"):     m.reg_idx = 5'd14;
      48'("DX"):     m.reg_idx = 5'd15;
      48'("EAX"):    m.reg_idx = 5'd16;
      48'("EBX"):    m.reg_idx = 5'd17;
      48'("EBP"):    m.reg_idx = 5'd18;
      48'("ECX"):    m.reg_idx = 5'd19;
      48'("EDX"):    m.reg_idx = 5'd20;
      48'("EDI"):    m.reg_idx = 5'd21;
      48'("ES"):     m.reg_idx = 5'd22;
      48'("ESI"):    m.reg_idx = 5'd23;
      48'("ESP"):    m.reg_idx = 5'd24;
      48'("EFLAGS"): m.reg_idx = 5'd25;
      48'("FS"):     m.reg_idx = 5'd26;
      48'("GS"):     m.reg_idx = 5'd27;
      48'("SI"):     m.reg_idx = 5'd28;
      48'("SP"):     m.reg_idx = 5'd29;
      48'("SS"):     m.reg_idx = 5'd30;
      default: begin
        m.reg_hit = 1'b0;
        m.reg_idx = '0;
      end
    endcase
    return m;
  endfunction

endpackage

@@ src/mclp_match.sv @@
// Command word and register name decoder of the command line parser.
// Depends on mclp_pkg for the name tables and the match type.
`timescale 1ns / 1ps

module mclp_match #(
  parameter int TOKEN_MAX = mclp_pkg::TOKEN_MAX_DEF,
  localparam int LEN_W = $clog2(TOKEN_MAX + 1)
) (
  input  logic [8*mclp_pkg::CMD_KEEP-1:0] cmd_word,
  input  logic [LEN_W-1:0]                cmd_len,
  input  logic [8*mclp_pkg::ARG_KEEP-1:0] arg_word,
  input  logic [LEN_W-1:0]                arg_len,
  output mclp_pkg::match_t                match
);

  mclp_pkg::match_t reg_m;

  always_comb begin
    reg_m = mclp_pkg::reg_lookup(arg_word);
    // Words longer than what is kept can never match a name.
    if (cmd_len > LEN_W'(mclp_pkg::CMD_KEEP)) begin
      match.cmd = mclp_pkg::CMD_ERROR;
    end else begin
      match.cmd = mclp_pkg::cmd_lookup(cmd_word);
    end
    if (arg_len > LEN_W'(mclp_pkg::ARG_KEEP)) begin
      match.reg_hit = 1'b0;
      match.reg_idx = '0;
    end else begin
      match.reg_hit = reg_m.reg_hit;
      match.reg_idx = reg_m.reg_idx;
    end
  end

endmodule

@@ src/mclp_state.sv @@
// Parser state registers, per-byte update and line result of the parser.
// Depends on mclp_pkg and on mclp_match for name decoding.
`timescale 1ns / 1ps

module mclp_state #(
  parameter int TOKEN_MAX = mclp_pkg::TOKEN_MAX_DEF,
  parameter int LINE_MAX  = mclp_pkg::LINE_MAX_DEF,
  parameter int ADDR_BITS = mclp_pkg::ADDR_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [7:0]        char_q,
  output mclp_pkg::result_t result
);

  localparam int LEN_W = $clog2(TOKEN_MAX + 1);
  localparam int CW_W  = 8 * mclp_pkg::CMD_KEEP;
  localparam int AW_W  = 8 * mclp_pkg::ARG_KEEP;

  typedef enum logic [5:0] {
    PH_START = 6'b000001,
    PH_CMD   = 6'b000010,
    PH_GAP   = 6'b000100,
    PH_ARG   = 6'b001000,
    PH_DONE  = 6'b010000,
    PH_EXTRA = 6'b100000
  } phase_t;

  phase_t                           phase, phase_next;
  logic [mclp_pkg::POS_W-1:0]       line_pos, line_pos_next;
  logic [CW_W-1:0]                  cmd_word, cmd_word_next;
  logic [LEN_W-1:0]                 cmd_len, cmd_len_next;
  logic [AW_W-1:0]                  arg_word, arg_word_next;
  logic [LEN_W-1:0]                 arg_len, arg_len_next;
  logic                             arg_hex, arg_hex_next;
  logic [ADDR_BITS-1:0]             hex_value, hex_value_next;
  logic                             hex_bad, hex_bad_next;
  logic                             hex_ovf, hex_ovf_next;
  logic [mclp_pkg::POS_W-1:0]       echo_pos, echo_pos_next;

  mclp_pkg::match_t match;
  logic             is_sep;
  logic             digit_ok;
  logic [3:0]       digit;
  logic             bad_now;
  logic [63:0]      hex_wide;

  mclp_match #(
    .TOKEN_MAX(TOKEN_MAX)
  ) u_match (
    .cmd_word(cmd_word),
    .cmd_len (cmd_len),
    .arg_word(arg_word),
    .arg_len (arg_len),
    .match   (match)
  );

  function automatic logic [7:0] fold(input logic [7:0] c);
    if (c >= "a" && c <= "z") begin
      return c - 8'd32;
    end
    return c;
  endfunction

  always_comb begin
    is_sep = (char_q == 8'd32) || (char_q == 8'd9) || (char_q == 8'd10);

    digit_ok = 1'b1;
    if (char_q >= "a" && char_q <= "f") begin
      digit = 4'(char_q - "a" + 8'd10);
    end else if (char_q >= "A" && char_q <= "F") begin
      digit = 4'(char_q - "A" + 8'd10);
    end else if (char_q >= "0" && char_q <= "9") begin
      digit = 4'(char_q - "0");
    end else begin
      digit    = 4'h0;
      digit_ok = 1'b0;
    end
    bad_now = hex_bad || !digit_ok;

    phase_next     = phase;
    line_pos_next  = line_pos;
    cmd_word_next  = cmd_word;
    cmd_len_next   = cmd_len;
    arg_word_next  = arg_word;
    arg_len_next   = arg_len;
    arg_hex_next   = arg_hex;
    hex_value_next = hex_value;
    hex_bad_next   = hex_bad;
    hex_ovf_next   = hex_ovf;
    echo_pos_next  = echo_pos;

    if (char_q == 8'h00) begin
      // A terminator closes the line and brings every register back to reset.
      phase_next     = PH_START;
      line_pos_next  = '0;
      cmd_word_next  = '0;
      cmd_len_next   = '0;
      arg_word_next  = '0;
      arg_len_next   = '0;
      arg_hex_next   = 1'b0;
      hex_value_next = '0;
      hex_bad_next   = 1'b0;
      hex_ovf_next   = 1'b0;
      echo_pos_next  = '0;
    end else begin
      case (phase)
        PH_START: begin
          if (!is_sep) begin
            phase_next    = PH_CMD;
            cmd_word_next = CW_W'(char_q);
            cmd_len_next  = LEN_W'(1);
          end
        end
        PH_CMD: begin
          if (is_sep) begin
            phase_next = (match.cmd == mclp_pkg::CMD_ERROR) ? PH_DONE : PH_GAP;
          end else begin
            if (cmd_len < LEN_W'(mclp_pkg::CMD_KEEP)) begin
              cmd_word_next = {cmd_word[CW_W-9:0], char_q};
            end
            cmd_len_next = cmd_len + LEN_W'(1);
            // A cut word is longer than any command, so the line is invalid.
            if (cmd_len_next >= LEN_W'(TOKEN_MAX)) begin
              phase_next = PH_DONE;
            end
          end
        end
        PH_GAP, PH_ARG: begin
          if (phase == PH_ARG && is_sep) begin
            phase_next = PH_DONE;
          end else if (phase == PH_GAP && is_sep) begin
            phase_next = PH_GAP;
          end else if (phase == PH_GAP && match.cmd == mclp_pkg::CMD_ECHO) begin
            echo_pos_next = line_pos;
            phase_next    = PH_DONE;
          end else if (phase == PH_GAP && match.cmd != mclp_pkg::CMD_PEEK
                       && match.cmd != mclp_pkg::CMD_POKE) begin
            phase_next = PH_EXTRA;
          end else begin
            phase_next = PH_ARG;
            if (arg_len < LEN_W'(mclp_pkg::ARG_KEEP)) begin
              arg_word_next = {arg_word[AW_W-9:0], fold(char_q)};
            end
            if (arg_len == LEN_W'(1) && arg_word[7:0] == "0" && char_q == "x") begin
              arg_hex_next = 1'b1;
            end
            if (arg_hex) begin
              hex_bad_next = bad_now;
              if (!bad_now && !hex_ovf) begin
                if (hex_value[ADDR_BITS-1 -: 4] != 4'h0) begin
                  hex_ovf_next = 1'b1;
                end else begin
                  hex_value_next = {hex_value[ADDR_BITS-5:0], digit};
                end
              end
            end
            arg_len_next = arg_len + LEN_W'(1);
            if (arg_len_next >= LEN_W'(TOKEN_MAX)) begin
              phase_next = PH_DONE;
            end
          end
        end
        default: begin
        end
      endcase
      if (line_pos < mclp_pkg::POS_W'(LINE_MAX)) begin
        line_pos_next = line_pos + mclp_pkg::POS_W'(1);
      end
    end
  end

  // Line result, meaningful in the cycle that the terminator is processed.
  always_comb begin
    hex_wide          = 64'(hex_value);
    result.command    = mclp_pkg::CMD_EMPTY;
    result.error_code = mclp_pkg::ERR_NONE;
    result.reg_index  = '0;
    result.address    = '0;
    result.addr_set   = 1'b0;
    result.reg_set    = 1'b0;
    result.echo_start = '0;
    if (phase != PH_START) begin
      if (match.cmd == mclp_pkg::CMD_ERROR) begin
        result.command    = mclp_pkg::CMD_ERROR;
        result.error_code = mclp_pkg::ERR_INVALID;
      end else if (match.cmd == mclp_pkg::CMD_ECHO) begin
        result.command    = mclp_pkg::CMD_ECHO;
        result.echo_start = (phase == PH_CMD || phase == PH_GAP) ? line_pos : echo_pos;
      end else if (match.cmd == mclp_pkg::CMD_PEEK || match.cmd == mclp_pkg::CMD_POKE) begin
        if (arg_len == '0) begin
          result.command    = mclp_pkg::CMD_ERROR;
          result.error_code = mclp_pkg::ERR_USAGE;
        end else if (arg_hex) begin
          if (hex_bad || hex_ovf) begin
            result.command    = mclp_pkg::CMD_ERROR;
            result.error_code = mclp_pkg::ERR_USAGE;
          end else begin
            result.command  = match.cmd;
            result.addr_set = 1'b1;
            result.address  = hex_wide[mclp_pkg::ADDR_OUT_W-1:0];
          end
        end else if (!match.reg_hit) begin
          result.command    = mclp_pkg::CMD_ERROR;
          result.error_code = mclp_pkg::ERR_USAGE;
        end else begin
          result.command   = match.cmd;
          result.reg_set   = 1'b1;
          result.reg_index = match.reg_idx;
        end
      end else if (phase == PH_EXTRA) begin
        result.error_code = mclp_pkg::ERR_EXTRA;
        // help, int and cpuid fall back to the help text on extra input.
        result.command = (match.cmd >= mclp_pkg::CMD_HELP) ? mclp_pkg::CMD_HELP
                                                            : mclp_pkg::CMD_ERROR;
      end else begin
        result.command = match.cmd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_START;
      line_pos  <= '0;
      cmd_word  <= '0;
      cmd_len   <= '0;
      arg_word  <= '0;
      arg_len   <= '0;
      arg_hex   <= 1'b0;
      hex_value <= '0;
      hex_bad   <= 1'b0;
      hex_ovf   <= 1'b0;
      echo_pos  <= '0;
    end else if (go) begin
      phase     <= phase_next;
      line_pos  <= line_pos_next;
      cmd_word  <= cmd_word_next;
      cmd_len   <= cmd_len_next;
      arg_word  <= arg_word_next;
      arg_len   <= arg_len_next;
      arg_hex   <= arg_hex_next;
      hex_value <= hex_value_next;
      hex_bad   <= hex_bad_next;
      hex_ovf   <= hex_ovf_next;
      echo_pos  <= echo_pos_next;
    end
  end

endmodule

@@ src/monitor_command_line_parser.sv @@
// Debug-monitor command line parser, one byte per beat, one result per line.
// A terminator byte passes the input register, then its line result is registered.
// Throughput: one byte per cycle; only a terminator waits in the input register,
// and only while the previous line result is still stalled at the output.
// Reset: synchronous active-high rst clears the parser to the start of a line.
// Depends on mclp_pkg, mclp_state and assert_macros.svh.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module monitor_command_line_parser #(
  parameter int TOKEN_MAX = mclp_pkg::TOKEN_MAX_DEF,
  parameter int LINE_MAX  = mclp_pkg::LINE_MAX_DEF,
  parameter int ADDR_BITS = mclp_pkg::ADDR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        char_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [3:0]                        command,
  output logic [1:0]                        error_code,
  output logic [mclp_pkg::REG_W-1:0]        reg_index,
  output logic [mclp_pkg::ADDR_OUT_W-1:0]   address,
  output logic                              addr_set,
  output logic                              reg_set,
  output logic [mclp_pkg::POS_W-1:0]        echo_start
);

  logic              s1_valid;
  logic [7:0]        s1_char;
  logic              s1_go;
  logic              out_free;
  logic              in_take;
  mclp_pkg::result_t result;
  mclp_pkg::result_t res_q;
  logic              s1_term;
  logic              s1_plain;
  logic              res_empty;
  logic              res_clean;
  logic              res_echo;

  // Only a terminator needs room in the result register; other bytes always flow.
  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid && (s1_char != 8'h00 || out_free);
  assign in_stall = s1_valid && !s1_go;
  assign in_take  = in_valid && !in_stall;

  mclp_state #(
    .TOKEN_MAX(TOKEN_MAX),
    .LINE_MAX (LINE_MAX),
    .ADDR_BITS(ADDR_BITS)
  ) u_state (
    .clk   (clk),
    .rst   (rst),
    .go    (s1_go),
    .char_q(s1_char),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char <= char_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_char == 8'h00) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_char == 8'h00) begin
      res_q <= result;
    end
  end

  assign command    = res_q.command;
  assign error_code = res_q.error_code;
  assign reg_index  = res_q.reg_index;
  assign address    = res_q.address;
  assign addr_set   = res_q.addr_set;
  assign reg_set    = res_q.reg_set;
  assign echo_start = res_q.echo_start;

  assign s1_term   = s1_valid && s1_char == 8'h00;
  assign s1_plain  = s1_go && s1_char != 8'h00;
  assign res_empty = command == mclp_pkg::CMD_EMPTY;
  assign res_clean = !addr_set && !reg_set && error_code == mclp_pkg::ERR_NONE;
  assign res_echo  = command == mclp_pkg::CMD_ECHO;

  `ASSERT_IMPL(a_rise_from_term, $rose(out_valid), $past(s1_term), "result without terminator")
  `ASSERT_IMPL(a_one_arg_kind, out_valid, !(addr_set && reg_set), "address and register both set")
  `ASSERT_IMPL(a_empty_clean, out_valid && res_empty, res_clean, "empty line carries flags")
  `ASSERT_IMPL(a_echo_only, out_valid && echo_start != '0, res_echo, "echo position on non-echo")
  `ASSERT_NEXT(a_plain_no_result, s1_plain && !out_valid, !out_valid, "plain byte made a result")

endmodule
